/* sv/scd_pkg.sv */
// Shared types, constants and helpers of the scan line color detector.
`default_nettype none
package scd_pkg;
	localparam int MAX_LINE_PIXELS = 1024;
	localparam int POS_W = $clog2(MAX_LINE_PIXELS + 1);
	localparam int ADDR_W = $clog2(MAX_LINE_PIXELS);
	localparam int CHAN_W = 8;
	localparam int SUM_W = CHAN_W + 2;
	localparam int LINE_W = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE_PIXELS);
	localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

	// floor(sum / 3) as (sum * 683) >> 11, exact for sums up to 765
	localparam int AVG_MUL_W = 10;
	localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(683);
	localparam int AVG_SHIFT = 11;
	localparam int PROD_W = SUM_W + AVG_MUL_W;

	localparam logic [CFG_DATA_W-1:0] DARK_LIMIT_RST = 8'd15;
	localparam logic [CFG_DATA_W-1:0] BRIGHT_LIMIT_RST = 8'd235;
	localparam logic [CFG_DATA_W-1:0] GRAY_TOL_RST = 8'd3;
	localparam logic [CFG_DATA_W-1:0] COLOR_THR_RST = 8'd18;
	localparam logic [CFG_DATA_W-1:0] STEP_THR_RST = 8'd28;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DARK_LIMIT = 3'd0,
		REG_BRIGHT_LIMIT = 3'd1,
		REG_GRAY_TOLERANCE = 3'd2,
		REG_COLOR_THRESHOLD = 3'd3,
		REG_STEP_THRESHOLD = 3'd4
	} scd_reg_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] dark_limit;
		logic [CFG_DATA_W-1:0] bright_limit;
		logic [CFG_DATA_W-1:0] gray_tolerance;
		logic [CFG_DATA_W-1:0] color_threshold;
		logic [CFG_DATA_W-1:0] step_threshold;
	} scd_cfg_t;

	typedef struct packed {
		logic re;
		logic [ADDR_W-1:0] raddr;
		logic we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAN_W-1:0] wdata;
	} scd_ram_req_t;

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction
endpackage
`default_nettype wire

/* sv/scd_ifs.sv */
// Valid/ready channel interfaces for pixels, line results and register writes.
`default_nettype none
interface scd_pix_if;
	logic valid;
	logic ready;
	logic [scd_pkg::CHAN_W-1:0] red;
	logic [scd_pkg::CHAN_W-1:0] green;
	logic [scd_pkg::CHAN_W-1:0] blue;
	logic start_scan;
	logic last_in_line;
	modport source (output valid, red, green, blue, start_scan, last_in_line, input ready);
	modport sink (input valid, red, green, blue, start_scan, last_in_line, output ready);
endinterface

interface scd_res_if;
	logic valid;
	logic ready;
	logic line_has_color;
	logic [scd_pkg::LINE_W-1:0] line_index;
	logic line_done;
	modport source (output valid, line_has_color, line_index, line_done, input ready);
	modport sink (input valid, line_has_color, line_index, line_done, output ready);
endinterface

interface scd_cfg_if;
	logic valid;
	logic ready;
	logic [scd_pkg::CFG_IDX_W-1:0] index;
	logic [scd_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/scd_row_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module scd_row_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* sv/scd_cfg_regs.sv */
// Threshold register file written through the configuration channel.
`default_nettype none
module scd_cfg_regs (
	input wire logic clk,
	input wire logic arst_n,
	scd_cfg_if.sink cfg,
	output scd_pkg::scd_cfg_t regs
);
	import scd_pkg::*;

	scd_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.dark_limit <= DARK_LIMIT_RST;
			regs_q.bright_limit <= BRIGHT_LIMIT_RST;
			regs_q.gray_tolerance <= GRAY_TOL_RST;
			regs_q.color_threshold <= COLOR_THR_RST;
			regs_q.step_threshold <= STEP_THR_RST;
		end else if (cfg.valid) begin
			case (scd_reg_t'(cfg.index))
				REG_DARK_LIMIT: regs_q.dark_limit <= cfg.data;
				REG_BRIGHT_LIMIT: regs_q.bright_limit <= cfg.data;
				REG_GRAY_TOLERANCE: regs_q.gray_tolerance <= cfg.data;
				REG_COLOR_THRESHOLD: regs_q.color_threshold <= cfg.data;
				REG_STEP_THRESHOLD: regs_q.step_threshold <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

/* sv/scd_core.sv */
// Two-stage pixel pipeline: address and average, then store compare, tests and result.
`default_nettype none
module scd_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire scd_pkg::scd_cfg_t regs,
	scd_pix_if.sink pixel,
	scd_res_if.source result,
	output scd_pkg::scd_ram_req_t ram_req,
	input wire logic [scd_pkg::CHAN_W-1:0] ram_rdata
);
	import scd_pkg::*;

	// stage 0
	logic in_ready;
	logic in_xfer;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_use;
	logic [SUM_W-1:0] sum;
	logic [PROD_W-1:0] prod;
	logic [CHAN_W-1:0] avg;
	logic fwd_hit;

	// stage 1
	logic valid_s1;
	logic start_s1;
	logic last_s1;
	logic [CHAN_W-1:0] red_s1;
	logic [CHAN_W-1:0] green_s1;
	logic [CHAN_W-1:0] blue_s1;
	logic [CHAN_W-1:0] avg_s1;
	logic [POS_W-1:0] pos_s1;
	logic fwd_s1;
	logic [CHAN_W-1:0] fwd_data_s1;

	logic [CHAN_W-1:0] prev_avg_q;
	logic hit_q;
	logic first_q;
	logic [LINE_W-1:0] cnt_q;

	logic out_valid_q;
	logic out_color_q;
	logic [LINE_W-1:0] out_index_q;

	logic out_free;
	logic s1_adv;
	logic eff_hit;
	logic eff_first;
	logic [LINE_W-1:0] eff_cnt;
	logic in_store;
	logic [CHAN_W-1:0] old_entry;
	logic [CHAN_W-1:0] dev_r;
	logic [CHAN_W-1:0] dev_g;
	logic [CHAN_W-1:0] dev_b;
	logic step_hit;
	logic skip;
	logic color_hit;
	logic row_hit;
	logic proc;
	logic new_hit;

	assign out_free = !out_valid_q || result.ready;
	assign s1_adv = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_adv;
	assign pixel.ready = in_ready;
	assign in_xfer = pixel.valid && in_ready;

	always_comb begin
		pos_use = pixel.start_scan ? '0 : pos_q;
		sum = SUM_W'(pixel.red) + SUM_W'(pixel.green) + SUM_W'(pixel.blue);
		prod = PROD_W'(sum) * PROD_W'(AVG_MUL);
		avg = prod[AVG_SHIFT +: CHAN_W];
	end

	always_comb begin
		eff_hit = start_s1 ? 1'b0 : hit_q;
		eff_first = start_s1 ? 1'b1 : first_q;
		eff_cnt = start_s1 ? '0 : cnt_q;
		in_store = pos_s1 < POS_MAX;
		old_entry = fwd_s1 ? fwd_data_s1 : ram_rdata;
		dev_r = abs_diff(red_s1, avg_s1);
		dev_g = abs_diff(green_s1, avg_s1);
		dev_b = abs_diff(blue_s1, avg_s1);
		step_hit = (pos_s1 != '0) && (abs_diff(avg_s1, prev_avg_q) > regs.step_threshold);
		skip = (avg_s1 < regs.dark_limit)
			|| !((dev_r > regs.gray_tolerance) || (dev_g > regs.gray_tolerance)
				|| (dev_b > regs.gray_tolerance))
			|| (avg_s1 > regs.bright_limit);
		color_hit = (dev_r > regs.color_threshold) || (dev_g > regs.color_threshold)
			|| (dev_b > regs.color_threshold);
		row_hit = !eff_first && in_store
			&& (abs_diff(old_entry, avg_s1) > regs.step_threshold);
		proc = !eff_hit;
		new_hit = eff_hit || (proc && (step_hit || (!skip && (color_hit || row_hit))));
	end

	always_comb begin
		ram_req.re = in_xfer;
		ram_req.raddr = pos_use[ADDR_W-1:0];
		ram_req.we = s1_adv && proc && !step_hit && in_store;
		ram_req.waddr = pos_s1[ADDR_W-1:0];
		ram_req.wdata = avg_s1;
		fwd_hit = ram_req.we && (ram_req.waddr == ram_req.raddr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (pixel.last_in_line) begin
					pos_q <= '0;
				end else if (pos_use < POS_MAX) begin
					pos_q <= pos_use + POS_W'(1);
				end else begin
					pos_q <= pos_use;
				end
			end
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			start_s1 <= pixel.start_scan;
			last_s1 <= pixel.last_in_line;
			red_s1 <= pixel.red;
			green_s1 <= pixel.green;
			blue_s1 <= pixel.blue;
			avg_s1 <= avg;
			pos_s1 <= pos_use;
			fwd_s1 <= fwd_hit;
			fwd_data_s1 <= ram_req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_avg_q <= '0;
			hit_q <= 1'b0;
			first_q <= 1'b1;
			cnt_q <= '0;
		end else if (s1_adv) begin
			if (proc && !step_hit) begin
				prev_avg_q <= avg_s1;
			end
			if (last_s1) begin
				hit_q <= 1'b0;
				first_q <= 1'b0;
				cnt_q <= (eff_cnt < LINE_MAX) ? eff_cnt + LINE_W'(1) : eff_cnt;
			end else begin
				hit_q <= new_hit;
				first_q <= eff_first;
				cnt_q <= eff_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			out_color_q <= new_hit;
			out_index_q <= eff_cnt;
		end
	end

	assign result.valid = out_valid_q;
	assign result.line_has_color = out_color_q;
	assign result.line_index = out_index_q;
	assign result.line_done = 1'b1;

`ifndef SYNTHESIS
	a_write_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> s1_adv)
		else $error("row store written without stage advance");
	a_stall_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && last_s1 && out_valid_q))
		else $error("input stalled with no pending line result");
	a_result_from_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_adv && last_s1))
		else $error("result raised without a line end");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("pixel position beyond line store");
`endif
endmodule
`default_nettype wire

/* sv/scan_line_color_detector_top.sv */
// Top level of the scan line color detector.
// Usage:
//   pixel  : valid/ready channel, one RGB pixel per transfer with start_scan
//            on the first pixel of an edge scan and last_in_line on the final
//            pixel of each line.
//   result : valid/ready channel, one transfer per finished line carrying
//            line_has_color, the saturating line_index and line_done = 1.
//   cfg    : register write channel (index, data); always ready. Write only
//            while no pixel is in flight.
// Throughput is one pixel per cycle unless a held line result stalls stage
// two; it is set by the single read and single write port of the line store,
// read in the first stage and written back in the second; a same-address
// write is forwarded to the read. A line's last pixel is registered into the
// second stage and its result into the output register once that is free.
// Reset clears the pipeline, the line state and the registers to their
// defaults; the line store is not cleared, so unwritten entries are unknown.
// When the result receiver stalls, one finished result waits in the output
// register; pixels keep flowing until a further last pixel reaches the second
// stage, which then holds and backpressures the pixel channel.
`default_nettype none
module scan_line_color_detector_top (
	input wire logic clk,
	input wire logic arst_n,
	scd_pix_if.sink pixel,
	scd_res_if.source result,
	scd_cfg_if.sink cfg
);
	import scd_pkg::*;

	scd_cfg_t regs;
	scd_ram_req_t ram_req;
	logic [CHAN_W-1:0] ram_rdata;

	scd_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.regs(regs)
	);

	scd_row_ram #(
		.DEPTH(MAX_LINE_PIXELS),
		.WIDTH(CHAN_W)
	) u_row_ram (
		.clk(clk),
		.we(ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re(ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	scd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.regs(regs),
		.pixel(pixel),
		.result(result),
		.ram_req(ram_req),
		.ram_rdata(ram_rdata)
	);
endmodule
`default_nettype wire

/* dv/scd_line_check_pkg.sv */
// Line-result predictor and scoreboard for the scan line color detector testbench.
`timescale 1ns / 1ps
package scd_line_check_pkg;
	import scd_pkg::*;

	typedef struct packed {
		logic has_color;
		logic [LINE_W-1:0] index;
		logic done;
	} line_result_t;

	class line_flag_board;
		logic [CFG_DATA_W-1:0] dark_lim;
		logic [CFG_DATA_W-1:0] bright_lim;
		logic [CFG_DATA_W-1:0] gray_tol;
		logic [CFG_DATA_W-1:0] color_thr;
		logic [CFG_DATA_W-1:0] step_thr;

		int unsigned row_avg [MAX_LINE_PIXELS];
		bit row_valid [MAX_LINE_PIXELS];
		int unsigned prev_avg;
		int unsigned pos;
		bit first_line;
		bit hit;
		logic [LINE_W-1:0] line_count;

		line_result_t expected_lines [$];
		int unsigned fail_count;

		function new();
			dark_lim = DARK_LIMIT_RST;
			bright_lim = BRIGHT_LIMIT_RST;
			gray_tol = GRAY_TOL_RST;
			color_thr = COLOR_THR_RST;
			step_thr = STEP_THR_RST;
			foreach (row_valid[i]) begin
				row_valid[i] = 1'b0;
				row_avg[i] = 0;
			end
			prev_avg = 0;
			pos = 0;
			first_line = 1'b1;
			hit = 1'b0;
			line_count = '0;
			fail_count = 0;
		endfunction

		function int unsigned span(int unsigned a, int unsigned b);
			return (a > b) ? a - b : b - a;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (scd_reg_t'(idx))
				REG_DARK_LIMIT: dark_lim = data;
				REG_BRIGHT_LIMIT: bright_lim = data;
				REG_GRAY_TOLERANCE: gray_tol = data;
				REG_COLOR_THRESHOLD: color_thr = data;
				REG_STEP_THRESHOLD: step_thr = data;
				default: ;
			endcase
		endfunction

		// true when the next pixel, on a later line with no hit yet, would reach a store entry never written
		function bit store_unset(bit start);
			int unsigned p;
			bit fl;
			bit h;
			p = start ? 0 : pos;
			fl = start ? 1'b1 : first_line;
			h = start ? 1'b0 : hit;
			return !h && !fl && p < MAX_LINE_PIXELS && !row_valid[p];
		endfunction

		function bit pixel_flags_line(int unsigned r, int unsigned g, int unsigned b);
			int unsigned a;
			int unsigned old;
			bit in_store;
			a = (r + g + b) / 3;
			old = 0;
			if (pos > 0 && span(a, prev_avg) > step_thr)
				return 1'b1;
			prev_avg = a;
			in_store = pos < MAX_LINE_PIXELS;
			if (in_store) begin
				old = row_avg[pos];
				row_avg[pos] = a;
				row_valid[pos] = 1'b1;
				pos++;
			end
			if (a < dark_lim)
				return 1'b0;
			if (span(r, a) <= gray_tol && span(g, a) <= gray_tol && span(b, a) <= gray_tol)
				return 1'b0;
			if (a > bright_lim)
				return 1'b0;
			if (span(r, a) > color_thr || span(g, a) > color_thr || span(b, a) > color_thr)
				return 1'b1;
			if (!first_line && in_store && span(old, a) > step_thr)
				return 1'b1;
			return 1'b0;
		endfunction

		function void note_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
			logic [CHAN_W-1:0] b, logic start, logic last);
			line_result_t res;
			if (start) begin
				line_count = '0;
				pos = 0;
				hit = 1'b0;
				first_line = 1'b1;
			end
			if (!hit && pixel_flags_line(32'(r), 32'(g), 32'(b)))
				hit = 1'b1;
			if (last) begin
				res.has_color = hit;
				res.index = line_count;
				res.done = 1'b1;
				expected_lines = {expected_lines, res};
				if (line_count != LINE_MAX)
					line_count++;
				first_line = 1'b0;
				hit = 1'b0;
				pos = 0;
			end
		endfunction

		function void check_line(line_result_t got);
			line_result_t exp_res;
			if (expected_lines.size() == 0) begin
				$error("line result with none expected: line_has_color %0d line_index %0d",
					got.has_color, got.index);
				fail_count++;
				return;
			end
			exp_res = expected_lines.pop_front();
			if (got.has_color !== exp_res.has_color) begin
				$error("line_has_color: expected %0d, got %0d", exp_res.has_color, got.has_color);
				fail_count++;
			end
			if (got.index !== exp_res.index) begin
				$error("line_index: expected %0d, got %0d", exp_res.index, got.index);
				fail_count++;
			end
			if (got.done !== exp_res.done) begin
				$error("line_done: expected %0d, got %0d", exp_res.done, got.done);
				fail_count++;
			end
		endfunction

		function int unsigned pending();
			return expected_lines.size();
		endfunction
	endclass
endpackage

/* dv/tb_scan_line_color_detector_top.sv */
// Testbench top: drives pixel lines and register writes, checks each line result.
`timescale 1ns / 1ps
module tb_scan_line_color_detector_top;
	import scd_pkg::*;
	import scd_line_check_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned PHASE_ITEMS = 40;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef enum {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} rx_pattern_t;
	typedef enum {LINE_SMOOTH, LINE_NOISE, LINE_FLAT} line_shape_t;
	typedef enum {LIM_ZERO, LIM_FULL, LIM_EDGE, LIM_ANY, LIM_TYPICAL} limit_kind_t;

	logic clk;
	logic arst_n;

	scd_pix_if pix();
	scd_res_if res();
	scd_cfg_if cfg();

	scan_line_color_detector_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pix),
		.result(res),
		.cfg(cfg)
	);

	line_flag_board board;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int line_level = 128;
	rx_pattern_t rx_pattern = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_tick = 0;
	limit_kind_t phase_plan [10];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_left == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 96);
			end
			rx_left--;
			rx_tick++;
			case (rx_pattern)
				RX_OPEN: res.ready <= 1'b1;
				RX_COIN: res.ready <= 1'($urandom_range(0, 1));
				RX_EVERY_THIRD: res.ready <= (rx_tick % 3) == 0;
				default: res.ready <= $urandom_range(0, 15) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (pix.valid === 1'b1 && pix.ready === 1'b1)
			board.note_pixel(pix.red, pix.green, pix.blue, pix.start_scan, pix.last_in_line);
		if (res.valid === 1'b1 && res.ready === 1'b1)
			board.check_line('{res.line_has_color, res.line_index, res.line_done});
		if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
			board.write_reg(cfg.index, cfg.data);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [CHAN_W-1:0] clip8(int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : CHAN_W'(v);
	endfunction

	function automatic int jitter(int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	task automatic push_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
		input logic [CHAN_W-1:0] b, input logic start, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				pix.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		// keep unwritten store entries out of the previous-line test
		if (board.store_unset(start)) begin
			g = r;
			b = r;
		end
		pix.red <= r;
		pix.green <= g;
		pix.blue <= b;
		pix.start_scan <= start;
		pix.last_in_line <= last;
		pix.valid <= 1'b1;
		@(posedge clk);
		while (pix.ready !== 1'b1) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		pix.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.index <= idx;
		cfg.data <= data;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (cfg.ready !== 1'b1) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_limits(input limit_kind_t kind);
		logic [CFG_DATA_W-1:0] v;
		scd_reg_t r;
		for (int i = 0; i <= int'(REG_STEP_THRESHOLD); i++) begin
			r = scd_reg_t'(i);
			case (kind)
				LIM_ZERO: v = 8'h00;
				LIM_FULL: v = 8'hFF;
				LIM_EDGE: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				LIM_ANY: v = CFG_DATA_W'($urandom_range(0, 255));
				default: begin
					case (r)
						REG_DARK_LIMIT: v = CFG_DATA_W'($urandom_range(0, 40));
						REG_BRIGHT_LIMIT: v = CFG_DATA_W'($urandom_range(200, 255));
						REG_GRAY_TOLERANCE: v = CFG_DATA_W'($urandom_range(0, 10));
						REG_COLOR_THRESHOLD: v = CFG_DATA_W'($urandom_range(4, 40));
						default: v = CFG_DATA_W'($urandom_range(4, 60));
					endcase
				end
			endcase
			write_reg(r, v);
		end
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_IDX_W'(REG_STEP_THRESHOLD) + CFG_IDX_W'($urandom_range(1, 3)),
				CFG_DATA_W'($urandom_range(0, 255)));
		cfg.valid <= 1'b0;
	endtask

	task automatic send_line(input line_shape_t shape, input int unsigned len, input logic start);
		int a;
		int drift;
		int dev;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic st;
		logic lst;
		line_level = int'(clip8(line_level + jitter(int'(board.step_thr) + 8)));
		a = (shape == LINE_FLAT) ? int'($urandom_range(0, 255)) : line_level;
		drift = $urandom_range(0, int'(board.step_thr) / 2 + 2);
		dev = $urandom_range(0, int'(board.color_thr) + int'(board.gray_tol) + 4);
		for (int unsigned i = 0; i < len; i++) begin
			st = start && i == 0;
			lst = i == len - 1;
			if (shape == LINE_NOISE || (shape == LINE_FLAT && i >= MAX_LINE_PIXELS)) begin
				r = CHAN_W'($urandom);
				g = CHAN_W'($urandom);
				b = CHAN_W'($urandom);
				if (shape == LINE_NOISE) begin
					st = st || $urandom_range(0, 19) == 0;
					lst = lst || $urandom_range(0, 9) == 0;
				end
			end else if (shape == LINE_FLAT) begin
				r = CHAN_W'(a);
				g = CHAN_W'(a);
				b = CHAN_W'(a);
			end else begin
				a = int'(clip8(a + jitter(drift)));
				r = clip8(a + jitter(dev));
				g = clip8(a + jitter(dev));
				b = clip8(a + jitter(dev));
			end
			push_pixel(r, g, b, st, lst);
		end
	endtask

	task automatic run_lines(input int unsigned budget);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		line_shape_t shape;
		logic start;
		sent = 0;
		start = 1'($urandom_range(0, 1));
		while (sent < budget) begin
			pick = $urandom_range(0, 19);
			shape = (pick < 12) ? LINE_SMOOTH : (pick < 17) ? LINE_NOISE : LINE_FLAT;
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			send_line(shape, len, start);
			sent += len;
			start = $urandom_range(0, 7) == 0;
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.red = '0;
		pix.green = '0;
		pix.blue = '0;
		pix.start_scan = 1'b0;
		pix.last_in_line = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		phase_plan = '{LIM_ZERO, LIM_FULL, LIM_TYPICAL, LIM_TYPICAL, LIM_EDGE,
			LIM_ANY, LIM_TYPICAL, LIM_ANY, LIM_TYPICAL, LIM_TYPICAL};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// dark, gray, mild color on the first line
		push_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
		push_pixel(8'd20, 8'd20, 8'd20, 1'b0, 1'b0);
		push_pixel(8'd40, 8'd40, 8'd41, 1'b0, 1'b0);
		push_pixel(8'd40, 8'd60, 8'd40, 1'b0, 1'b1);
		// jump from the previous line, then ignored pixels
		push_pixel(8'd30, 8'd34, 8'd26, 1'b0, 1'b0);
		push_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
		push_pixel(8'd0, 8'd255, 8'd255, 1'b0, 1'b1);
		// colored single-pixel line
		push_pixel(8'd200, 8'd40, 8'd40, 1'b0, 1'b1);
		// bright, white, jump from the neighbor
		push_pixel(8'd255, 8'd250, 8'd240, 1'b0, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
		push_pixel(8'd128, 8'd128, 8'd128, 1'b0, 1'b1);
		// new scan on a one-pixel line
		push_pixel(8'd255, 8'd0, 8'd255, 1'b1, 1'b1);
		push_pixel(8'd128, 8'd128, 8'd128, 1'b0, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd0, 1'b0, 1'b1);
		// scan restart in the middle of a line
		push_pixel(8'd100, 8'd100, 8'd100, 1'b0, 1'b0);
		push_pixel(8'd100, 8'd100, 8'd100, 1'b1, 1'b1);

		for (int k = 0; k < 10; k++) begin
			settle();
			load_limits(phase_plan[k]);
			run_lines(PHASE_ITEMS);
		end

		pix.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

/* scan_line_color_detector_top.f */
sv/scd_pkg.sv
sv/scd_ifs.sv
sv/scd_row_ram.sv
sv/scd_cfg_regs.sv
sv/scd_core.sv
sv/scan_line_color_detector_top.sv
dv/scd_line_check_pkg.sv
dv/tb_scan_line_color_detector_top.sv
